// ===== src/ewc_pkg.sv =====
// ============================================================================
// Elementwise combine package
// Shared widths, codes, word types and saturation helpers.
// ============================================================================
package ewc_pkg;

    localparam int WORD_W       = 32;
    localparam int PROD_W       = 2 * WORD_W;
    localparam int ACC_W        = PROD_W + 2;
    localparam int FIELD_INPUTS = 4;
    localparam int CNT_W        = 3;
    localparam int WIN_W        = 2;
    localparam int MODE_W       = 2;
    localparam int CFG_IDX_W    = 3;

    localparam int DEF_MAX_INPUTS = 4;
    localparam int DEF_FRAC_BITS  = 16;

    // Operation codes.
    localparam logic [MODE_W-1:0] MODE_PROD = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SUM  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_MAX  = 2'd2;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MODE        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COEFF_ZERO  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COEFF_ONE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COEFF_TWO   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_COEFF_THREE = 3'd5;

    localparam logic [CNT_W-1:0]         MIN_COUNT = 3'd2;
    localparam logic [CNT_W-1:0]         RST_COUNT = 3'd2;
    localparam logic signed [WORD_W-1:0] RST_COEFF = 32'sd65536;

    localparam logic [WIN_W-1:0] WIN_ZERO = 2'd0;
    localparam logic [WIN_W-1:0] WIN_ONE  = 2'd1;

    localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7fff_ffff;
    localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic signed [WORD_W-1:0] value_zero;
        logic signed [WORD_W-1:0] value_one;
        logic signed [WORD_W-1:0] value_two;
        logic signed [WORD_W-1:0] value_three;
        logic                     last_in;
    } t_in_word;

    typedef struct packed {
        logic signed [WORD_W-1:0] combined;
        logic [WIN_W-1:0]         winner_index;
        logic                     last_out;
    } t_out_word;

    // Control that travels with each word down the pipeline.
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [CNT_W-1:0]  count;
        logic              last;
    } t_ctrl;

    // Sign-extends a full product to the accumulator width.
    function automatic logic signed [ACC_W-1:0] widen(input logic signed [PROD_W-1:0] x);
        widen = {{(ACC_W - PROD_W){x[PROD_W-1]}}, x};
    endfunction

    // Clamps an accumulator value to the signed word range.
    function automatic logic signed [WORD_W-1:0] sat_word(
        input logic signed [ACC_W-1:0] x
    );
        logic [ACC_W-WORD_W:0] top;
        top = x[ACC_W-1:WORD_W-1];
        if (top == '0 || top == '1) begin
            sat_word = x[WORD_W-1:0];
        end else if (x[ACC_W-1]) begin
            sat_word = WORD_MIN;
        end else begin
            sat_word = WORD_MAX;
        end
    endfunction

endpackage

// ===== src/ewc_lane.sv =====
// ============================================================================
// Elementwise combine multiplier lane
// Signed word by word multiply with a registered full-width product.
// ============================================================================
module ewc_lane (
    input  logic                                 i_clk,
    input  logic                                 i_en,
    input  logic signed [ewc_pkg::WORD_W-1:0]    i_a,
    input  logic signed [ewc_pkg::WORD_W-1:0]    i_b,
    output logic signed [ewc_pkg::PROD_W-1:0]    o_prod
);
    import ewc_pkg::*;

    logic signed [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= i_a * i_b;
        end
    end

    assign o_prod = r_prod;

endmodule

// ===== src/ewc_merge.sv =====
// ============================================================================
// Elementwise combine merge stage
// Adds the lane products of the active inputs and picks the maximum input.
// ============================================================================
module ewc_merge #(
    parameter int N_LANES = ewc_pkg::DEF_MAX_INPUTS
) (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  ewc_pkg::t_ctrl                    i_ctrl,
    input  ewc_pkg::t_in_word                 i_data,
    input  logic signed [ewc_pkg::PROD_W-1:0] i_prod [N_LANES],
    output logic signed [ewc_pkg::ACC_W-1:0]  o_sum,
    output logic signed [ewc_pkg::WORD_W-1:0] o_max,
    output logic [ewc_pkg::WIN_W-1:0]         o_win
);
    import ewc_pkg::*;

    logic signed [ACC_W-1:0]  sum;
    logic signed [WORD_W-1:0] vals [FIELD_INPUTS];
    logic signed [WORD_W-1:0] best;
    logic [WIN_W-1:0]         best_idx;

    logic signed [ACC_W-1:0]  r_sum;
    logic signed [WORD_W-1:0] r_max;
    logic [WIN_W-1:0]         r_win;

    assign vals[0] = i_data.value_zero;
    assign vals[1] = i_data.value_one;
    assign vals[2] = i_data.value_two;
    assign vals[3] = i_data.value_three;

    // The exact sum of the lane products; rounding happens after the add.
    always_comb begin
        sum = '0;
        for (int i = 0; i < N_LANES; i++) begin
            if (CNT_W'(i) < i_ctrl.count) begin
                sum = sum + widen(i_prod[i]);
            end
        end
    end

    // Input one wins a tie with input zero; later inputs need strictly more.
    always_comb begin
        if (vals[0] > vals[1]) begin
            best     = vals[0];
            best_idx = WIN_ZERO;
        end else begin
            best     = vals[1];
            best_idx = WIN_ONE;
        end
        for (int i = 2; i < FIELD_INPUTS; i++) begin
            if (CNT_W'(i) < i_ctrl.count && vals[i] > best) begin
                best     = vals[i];
                best_idx = WIN_W'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum <= sum;
            r_max <= best;
            r_win <= best_idx;
        end
    end

    assign o_sum = r_sum;
    assign o_max = r_max;
    assign o_win = r_win;

endmodule

// ===== src/elementwise_combine.sv =====
// ============================================================================
// Elementwise combine
// Combines the same-position element of up to four input tensors.
// ============================================================================
// The block takes one word per clock while not stalled, carrying the
// same-position element of up to four signed fixed-point tensors, and
// returns one combined word per accepted word, in order. Mode product
// multiplies the active inputs in order, flooring and saturating after
// each step; mode sum forms the exact coefficient-weighted sum, floors it
// once and saturates it; mode maximum returns the largest active input and
// its index, where input one wins a tie with input zero and later inputs
// win only when strictly greater. An unused mode code gives zero. The last
// flag travels with its word. The block sustains one word per clock while
// the output is not stalled; product mode runs three dependent multipliers
// with a register after each. The input stall only rises when every
// pipeline stage and the output register hold words that cannot move.
// Registers are to be written only while idle; the block does not check.
// ============================================================================
module elementwise_combine #(
    parameter int MAX_INPUTS = ewc_pkg::DEF_MAX_INPUTS,
    parameter int FRAC_BITS  = ewc_pkg::DEF_FRAC_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Input word channel.
    input  logic                                i_valid,
    output logic                                o_stall,
    input  ewc_pkg::t_in_word                   i_in_data,
    // Output word channel.
    output logic                                o_valid,
    input  logic                                i_stall,
    output ewc_pkg::t_out_word                  o_out_data,
    // Register write port.
    input  logic                                i_cfg_we,
    input  logic [ewc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [ewc_pkg::WORD_W-1:0]          i_cfg_data
);
    import ewc_pkg::*;

    // Only as many lanes as there are input fields can ever be active.
    localparam int N_LANES = (MAX_INPUTS < FIELD_INPUTS) ? MAX_INPUTS : FIELD_INPUTS;

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic [MODE_W-1:0]        r_mode;
    logic [CNT_W-1:0]         r_count;
    logic signed [WORD_W-1:0] r_coeff [FIELD_INPUTS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_SUM;
            r_count <= RST_COUNT;
            for (int i = 0; i < FIELD_INPUTS; i++) begin
                r_coeff[i] <= RST_COEFF;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MODE:        r_mode     <= i_cfg_data[MODE_W-1:0];
                CFG_COUNT:       r_count    <= i_cfg_data[CNT_W-1:0];
                CFG_COEFF_ZERO:  r_coeff[0] <= i_cfg_data;
                CFG_COEFF_ONE:   r_coeff[1] <= i_cfg_data;
                CFG_COEFF_TWO:   r_coeff[2] <= i_cfg_data;
                CFG_COEFF_THREE: r_coeff[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // The active count is clamped to two at the low end and to the lane
    // count at the high end.
    logic [CNT_W-1:0] act_count;

    always_comb begin
        if (r_count < MIN_COUNT) begin
            act_count = MIN_COUNT;
        end else if (r_count > CNT_W'(N_LANES)) begin
            act_count = CNT_W'(N_LANES);
        end else begin
            act_count = r_count;
        end
    end

    // ------------------------------------------------------------------
    // Pipeline flow control. Each stage moves when the stage after it is
    // empty or moving, so bubbles close up under a stalled output.
    // ------------------------------------------------------------------
    logic r1_v, r2_v, r3_v, r_out_v;
    logic adv1, adv2, adv3, adv4;

    assign adv4    = !r_out_v || !i_stall;
    assign adv3    = !r3_v || adv4;
    assign adv2    = !r2_v || adv3;
    assign adv1    = !r1_v || adv2;
    assign o_stall = !adv1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v    <= 1'b0;
            r2_v    <= 1'b0;
            r3_v    <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (adv1) r1_v    <= i_valid;
            if (adv2) r2_v    <= r1_v;
            if (adv3) r3_v    <= r2_v;
            if (adv4) r_out_v <= r3_v;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: the lanes. In sum mode each lane forms coefficient times
    // value; in product mode lane zero forms value zero times value one.
    // ------------------------------------------------------------------
    logic signed [WORD_W-1:0] in_vals [FIELD_INPUTS];
    logic signed [WORD_W-1:0] lane_b  [N_LANES];
    logic signed [PROD_W-1:0] lane_prod [N_LANES];
    t_ctrl                    r1_ctrl;
    t_in_word                 r1_data;

    assign in_vals[0] = i_in_data.value_zero;
    assign in_vals[1] = i_in_data.value_one;
    assign in_vals[2] = i_in_data.value_two;
    assign in_vals[3] = i_in_data.value_three;

    always_comb begin
        for (int i = 0; i < N_LANES; i++) begin
            lane_b[i] = r_coeff[i];
        end
        if (r_mode == MODE_PROD) begin
            lane_b[0] = in_vals[1];
        end
    end

    for (genvar g = 0; g < N_LANES; g++) begin : g_lane
        ewc_lane u_lane (
            .i_clk  (i_clk),
            .i_en   (adv1),
            .i_a    (in_vals[g]),
            .i_b    (lane_b[g]),
            .o_prod (lane_prod[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r1_ctrl.mode  <= r_mode;
            r1_ctrl.count <= act_count;
            r1_ctrl.last  <= i_in_data.last_in;
            r1_data       <= i_in_data;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: the merge of lane results, and the first product step.
    // ------------------------------------------------------------------
    logic signed [ACC_W-1:0]  merge_sum;
    logic signed [WORD_W-1:0] merge_max;
    logic [WIN_W-1:0]         merge_win;
    logic signed [WORD_W-1:0] acc1;
    logic signed [PROD_W-1:0] chain2_prod;
    logic signed [WORD_W-1:0] r2_acc1;
    logic signed [WORD_W-1:0] r2_val3;
    t_ctrl                    r2_ctrl;

    ewc_merge #(
        .N_LANES (N_LANES)
    ) u_merge (
        .i_clk  (i_clk),
        .i_en   (adv2),
        .i_ctrl (r1_ctrl),
        .i_data (r1_data),
        .i_prod (lane_prod),
        .o_sum  (merge_sum),
        .o_max  (merge_max),
        .o_win  (merge_win)
    );

    assign acc1 = sat_word(widen(lane_prod[0]) >>> FRAC_BITS);

    ewc_lane u_chain2 (
        .i_clk  (i_clk),
        .i_en   (adv2),
        .i_a    (acc1),
        .i_b    (r1_data.value_two),
        .o_prod (chain2_prod)
    );

    always_ff @(posedge i_clk) begin
        if (adv2) begin
            r2_ctrl <= r1_ctrl;
            r2_acc1 <= acc1;
            r2_val3 <= r1_data.value_three;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: the second product step and the mode selection.
    // ------------------------------------------------------------------
    logic signed [WORD_W-1:0] acc2;
    logic signed [PROD_W-1:0] chain3_prod;
    logic signed [WORD_W-1:0] res3;
    logic [WIN_W-1:0]         win3;
    logic signed [WORD_W-1:0] r3_res;
    logic [WIN_W-1:0]         r3_win;
    t_ctrl                    r3_ctrl;

    assign acc2 = sat_word(widen(chain2_prod) >>> FRAC_BITS);

    ewc_lane u_chain3 (
        .i_clk  (i_clk),
        .i_en   (adv3),
        .i_a    (acc2),
        .i_b    (r2_val3),
        .o_prod (chain3_prod)
    );

    always_comb begin
        win3 = WIN_ZERO;
        case (r2_ctrl.mode)
            MODE_PROD: res3 = (r2_ctrl.count == MIN_COUNT) ? r2_acc1 : acc2;
            MODE_SUM:  res3 = sat_word(merge_sum >>> FRAC_BITS);
            MODE_MAX: begin
                res3 = merge_max;
                win3 = merge_win;
            end
            default:   res3 = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (adv3) begin
            r3_ctrl <= r2_ctrl;
            r3_res  <= res3;
            r3_win  <= win3;
        end
    end

    // ------------------------------------------------------------------
    // Output register. With four active inputs in product mode the last
    // product step is rounded and saturated here.
    // ------------------------------------------------------------------
    logic signed [WORD_W-1:0] acc3;
    t_out_word                r_out;

    assign acc3 = sat_word(widen(chain3_prod) >>> FRAC_BITS);

    always_ff @(posedge i_clk) begin
        if (adv4) begin
            if (r3_ctrl.mode == MODE_PROD && r3_ctrl.count == CNT_W'(FIELD_INPUTS)) begin
                r_out.combined <= acc3;
            end else begin
                r_out.combined <= r3_res;
            end
            r_out.winner_index <= r3_win;
            r_out.last_out     <= r3_ctrl.last;
        end
    end

    assign o_valid    = r_out_v;
    assign o_out_data = r_out;

endmodule

// ===== bench/tb_elementwise_combine.sv =====
// ============================================================================
// Elementwise combine testbench
// Checks every output word of the block against an in-bench model.
// ============================================================================
// A driver process feeds input words from a queue, a monitor process checks
// each output word against the oldest predicted word, and one initial block
// sequences the register settings and fills the queue. Both sides idle and
// stall at random, apart from one stretch with no idling and one long
// output hold-off that backs the block up into its input stall.
// ============================================================================
module tb_elementwise_combine;

    import ewc_pkg::*;

    localparam int FRAC         = DEF_FRAC_BITS;
    localparam int LIVE_INPUTS  = (DEF_MAX_INPUTS < FIELD_INPUTS) ? DEF_MAX_INPUTS
                                                                  : FIELD_INPUTS;
    localparam int IDLE_PCT     = 38;
    localparam int DRAIN_CYCLES = 10;
    localparam int HOLD_CYCLES  = 80;
    localparam int PHASES       = 13;
    localparam int PHASE_WORDS  = 65;
    localparam int PRESS_PHASE  = 5;
    localparam int CALM_PHASE   = 9;

    localparam logic signed [WORD_W-1:0] ONE_Q    = 32'sd65536;
    localparam logic signed [ACC_W+5:0]  WIDE_MAX = WORD_MAX;
    localparam logic signed [ACC_W+5:0]  WIDE_MIN = WORD_MIN;

    // Clock, reset and every input of the block start at known values.
    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_valid     = 1'b0;
    logic                   o_stall;
    t_in_word               i_in_data   = '0;
    logic                   o_valid;
    logic                   i_stall     = 1'b0;
    t_out_word              o_out_data;
    logic                   i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index = CFG_MODE;
    logic [WORD_W-1:0]      i_cfg_data  = '0;

    // Shadow copy of the register file, as the block holds it after reset.
    logic [MODE_W-1:0]        cfg_mode  = MODE_SUM;
    logic [CNT_W-1:0]         cfg_count = RST_COUNT;
    logic signed [WORD_W-1:0] cfg_coeff [FIELD_INPUTS] = '{default: RST_COEFF};

    // Words waiting to be offered, and results predicted but not yet seen.
    t_in_word  feed_words[$];
    t_out_word awaited_results[$];
    t_out_word want;

    // Idling controls shared by the sequencing block and the two ports.
    bit calm_src      = 1'b0;
    bit calm_sink     = 1'b0;
    bit sink_hold     = 1'b0;
    bit pressure_req  = 1'b0;

    int err_count       = 0;
    int results_checked = 0;
    int stall_cycles    = 0;
    int settings_run    = 0;
    int words_by_mode [3] = '{default: 0};

    logic [MODE_W-1:0] mode_order [3] = '{MODE_PROD, MODE_SUM, MODE_MAX};

    elementwise_combine dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_in_data   (i_in_data),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Clamps a wide exact value to the signed word range.
    function automatic logic signed [WORD_W-1:0] clamp_word(
        input logic signed [ACC_W+5:0] x
    );
        if (x > WIDE_MAX) begin
            return WORD_MAX;
        end else if (x < WIDE_MIN) begin
            return WORD_MIN;
        end
        return x[WORD_W-1:0];
    endfunction

    // Works out the output word for one input word under the current registers.
    // Product floors and saturates after every multiply; the sum is formed
    // exactly over 72 bits and floored once, which equals splitting each term
    // into its floored high part and its fraction bits.
    function automatic t_out_word predict_combined(input t_in_word w);
        logic signed [WORD_W-1:0] v [FIELD_INPUTS];
        logic signed [ACC_W+5:0]  a;
        logic signed [ACC_W+5:0]  b;
        logic signed [ACC_W+5:0]  sum;
        logic signed [WORD_W-1:0] run;
        logic [WIN_W-1:0]         win;
        t_out_word                r;
        int                       n;
        v[0] = w.value_zero;
        v[1] = w.value_one;
        v[2] = w.value_two;
        v[3] = w.value_three;
        n = int'(cfg_count);
        if (n < int'(MIN_COUNT)) begin
            n = int'(MIN_COUNT);
        end
        if (n > LIVE_INPUTS) begin
            n = LIVE_INPUTS;
        end
        r = '0;
        r.last_out = w.last_in;
        case (cfg_mode)
            MODE_PROD: begin
                a = v[0];
                b = v[1];
                run = clamp_word((a * b) >>> FRAC);
                for (int i = 2; i < n; i++) begin
                    a = run;
                    b = v[i];
                    run = clamp_word((a * b) >>> FRAC);
                end
                r.combined = run;
            end
            MODE_SUM: begin
                sum = '0;
                for (int i = 0; i < n; i++) begin
                    a = cfg_coeff[i];
                    b = v[i];
                    sum = sum + a * b;
                end
                r.combined = clamp_word(sum >>> FRAC);
            end
            MODE_MAX: begin
                // Input one takes a tie with input zero; later inputs must beat it.
                if (v[0] > v[1]) begin
                    run = v[0];
                    win = WIN_ZERO;
                end else begin
                    run = v[1];
                    win = WIN_ONE;
                end
                for (int i = 2; i < n; i++) begin
                    if (v[i] > run) begin
                        run = v[i];
                        win = WIN_W'(i);
                    end
                end
                r.combined = run;
                r.winner_index = win;
            end
            default: begin
                r.combined = '0;
            end
        endcase
        return r;
    endfunction

    // Prints one line per mismatch and counts it.
    task automatic report_mismatch(input string what, input longint got, input longint exp_v);
        $display("mismatch on %s at result %0d: got %0d, expected %0d",
                 what, results_checked, got, exp_v);
        err_count++;
    endtask

    // Driver: records each accepted word's prediction, then offers the next
    // queued word unless it chooses to idle. A stalled word is held as is.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                awaited_results.push_back(predict_combined(i_in_data));
                words_by_mode[int'(cfg_mode)]++;
            end
            if (i_valid && o_stall) begin
                stall_cycles++;
            end
            if (!i_valid || !o_stall) begin
                if (feed_words.size() != 0
                    && (calm_src || $urandom_range(99) >= IDLE_PCT)) begin
                    i_in_data <= feed_words.pop_front();
                    i_valid   <= 1'b1;
                end else begin
                    i_valid   <= 1'b0;
                end
            end
        end
    end

    // Monitor: every accepted output word is compared field by field with
    // the oldest prediction. The stall it drives never looks at o_valid.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (awaited_results.size() == 0) begin
                    report_mismatch("unexpected word", o_out_data.combined, 0);
                end else begin
                    want = awaited_results.pop_front();
                    if (o_out_data.combined !== want.combined) begin
                        report_mismatch("combined", o_out_data.combined, want.combined);
                    end
                    if (o_out_data.winner_index !== want.winner_index) begin
                        report_mismatch("winner_index", o_out_data.winner_index,
                                        want.winner_index);
                    end
                    if (o_out_data.last_out !== want.last_out) begin
                        report_mismatch("last_out", o_out_data.last_out, want.last_out);
                    end
                end
                results_checked++;
            end
            i_stall <= sink_hold || (!calm_sink && $urandom_range(99) < IDLE_PCT);
        end
    end

    // Long output hold-off, counted here in its own process, so that the
    // pipeline fills and the block raises its input stall.
    initial begin
        @(posedge pressure_req);
        sink_hold = 1'b1;
        repeat (HOLD_CYCLES) @(negedge i_clk);
        sink_hold = 1'b0;
    end

    // Hard stop in case the block hangs.
    initial begin
        #400000;
        $display("TEST FAILED");
        $finish;
    end

    // Random field value, weighted toward the extremes and toward values
    // near one so that products do not always saturate.
    function automatic logic signed [WORD_W-1:0] random_value();
        int x;
        case ($urandom_range(7))
            0: return WORD_MAX;
            1: return WORD_MIN;
            2: return '0;
            3: begin
                x = $urandom_range(0, 131072);
                return x - 65536;
            end
            4: begin
                x = $urandom_range(0, 1 << 20);
                return x - (1 << 19);
            end
            5: return ($urandom_range(1) == 0) ? -32'sd1 : 32'sd1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic signed [WORD_W-1:0] random_coeff();
        case ($urandom_range(5))
            0: return WORD_MAX;
            1: return WORD_MIN;
            2: return ONE_Q;
            3: return -ONE_Q;
            4: return random_value();
            default: return $urandom;
        endcase
    endfunction

    // Random word; about half carry equal values to exercise max ties.
    function automatic t_in_word random_word();
        t_in_word w;
        w.value_zero  = random_value();
        w.value_one   = random_value();
        w.value_two   = random_value();
        w.value_three = random_value();
        w.last_in     = ($urandom_range(7) == 0);
        case ($urandom_range(7))
            0: w.value_one = w.value_zero;
            1: w.value_two = w.value_one;
            2: w.value_three = w.value_zero;
            3: begin
                w.value_one   = w.value_zero;
                w.value_two   = w.value_zero;
                w.value_three = w.value_zero;
            end
            default: ;
        endcase
        return w;
    endfunction

    task automatic push_word(
        input logic signed [WORD_W-1:0] v0, input logic signed [WORD_W-1:0] v1,
        input logic signed [WORD_W-1:0] v2, input logic signed [WORD_W-1:0] v3,
        input logic last
    );
        t_in_word w;
        w.value_zero  = v0;
        w.value_one   = v1;
        w.value_two   = v2;
        w.value_three = v3;
        w.last_in     = last;
        feed_words.push_back(w);
    endtask

    // Waits until every queued word has gone in and every result has come
    // out, then lets the pipeline settle for its latency and a margin.
    task automatic drain_block();
        while (feed_words.size() != 0 || i_valid || awaited_results.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [WORD_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        case (index)
            CFG_MODE:        cfg_mode     = data[MODE_W-1:0];
            CFG_COUNT:       cfg_count    = data[CNT_W-1:0];
            CFG_COEFF_ZERO:  cfg_coeff[0] = data;
            CFG_COEFF_ONE:   cfg_coeff[1] = data;
            CFG_COEFF_TWO:   cfg_coeff[2] = data;
            CFG_COEFF_THREE: cfg_coeff[3] = data;
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Rewrites the whole register file once the block has gone idle.
    task automatic set_config(
        input logic [MODE_W-1:0] mode_code, input int count,
        input logic signed [WORD_W-1:0] c0, input logic signed [WORD_W-1:0] c1,
        input logic signed [WORD_W-1:0] c2, input logic signed [WORD_W-1:0] c3
    );
        drain_block();
        write_reg(CFG_MODE, WORD_W'(mode_code));
        write_reg(CFG_COUNT, WORD_W'(count));
        write_reg(CFG_COEFF_ZERO, c0);
        write_reg(CFG_COEFF_ONE, c1);
        write_reg(CFG_COEFF_TWO, c2);
        write_reg(CFG_COEFF_THREE, c3);
        @(negedge i_clk);
        settings_run++;
    endtask

    // Sequencing: reset, a directed pass over the corner cases of each mode,
    // then random phases that walk through modes, counts and coefficients.
    initial begin
        logic [MODE_W-1:0] mode_code;
        int                count;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset settings: unity weighted sum of two inputs. Full-scale
        // inputs saturate both ways; minus one LSB floors toward minus one.
        settings_run++;
        push_word(WORD_MAX, WORD_MAX, '0, '0, 1'b0);
        push_word(WORD_MIN, WORD_MIN, '0, '0, 1'b0);
        push_word(-32'sd1, '0, '0, '0, 1'b1);

        // Product over four inputs, with extreme weights loaded for later.
        set_config(MODE_PROD, 4, WORD_MAX, WORD_MIN, -ONE_Q, 32'sd1);
        push_word(WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, 1'b0);
        push_word(WORD_MIN, WORD_MAX, ONE_Q, ONE_Q, 1'b0);
        push_word(ONE_Q, ONE_Q, ONE_Q, ONE_Q, 1'b0);
        push_word(-32'sd1, 32'sd1, ONE_Q, ONE_Q, 1'b0);
        push_word('0, WORD_MAX, WORD_MIN, WORD_MIN, 1'b0);
        push_word(32'sd131072, -32'sd98304, 32'sd32768, 32'sd3, 1'b1);

        // Maximum: ties between the first two, ties that later inputs must
        // not win, a strict winner at the top index, and all-minimum words.
        set_config(MODE_MAX, 4, WORD_MAX, WORD_MIN, -ONE_Q, 32'sd1);
        push_word(32'sd5, 32'sd5, '0, '0, 1'b0);
        push_word(32'sd1, 32'sd5, 32'sd5, 32'sd5, 1'b0);
        push_word(32'sd1, 32'sd2, 32'sd3, 32'sd4, 1'b0);
        push_word(WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, 1'b0);
        push_word(32'sd7, 32'sd3, 32'sd9, 32'sd9, 1'b0);
        push_word(WORD_MAX, WORD_MIN, WORD_MIN, WORD_MIN, 1'b1);

        // Weighted sum with full-scale weights of both signs.
        set_config(MODE_SUM, 4, WORD_MAX, WORD_MIN, -ONE_Q, 32'sd1);
        push_word(WORD_MAX, WORD_MIN, WORD_MIN, WORD_MAX, 1'b0);
        push_word(WORD_MAX, WORD_MAX, WORD_MIN, WORD_MIN, 1'b0);
        push_word(32'sd1, 32'sd1, -32'sd1, -32'sd1, 1'b0);
        push_word('0, '0, '0, '0, 1'b1);

        // Two-input product at the negative extreme.
        set_config(MODE_PROD, 2, ONE_Q, ONE_Q, ONE_Q, ONE_Q);
        push_word(WORD_MIN, WORD_MIN, WORD_MAX, WORD_MAX, 1'b0);
        push_word(WORD_MIN, -32'sd1, '0, '0, 1'b1);

        for (int p = 0; p < PHASES; p++) begin
            mode_code = mode_order[p % 3];
            count = (p < 3) ? 2 : (p < 6) ? 4 : $urandom_range(2, 4);
            if (p == 1) begin
                set_config(mode_code, count, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX);
            end else if (p == 4) begin
                set_config(mode_code, count, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN);
            end else begin
                set_config(mode_code, count, random_coeff(), random_coeff(),
                           random_coeff(), random_coeff());
            end
            if (p == PRESS_PHASE) begin
                // The sender offers every cycle while the output is held off.
                calm_src     = 1'b1;
                pressure_req = 1'b1;
            end
            if (p == CALM_PHASE) begin
                calm_src  = 1'b1;
                calm_sink = 1'b1;
            end
            for (int k = 0; k < PHASE_WORDS; k++) begin
                feed_words.push_back(random_word());
            end
            drain_block();
            calm_src  = 1'b0;
            calm_sink = 1'b0;
        end

        drain_block();
        $display("Ran %0d register settings: %0d product, %0d sum, %0d maximum words.",
                 settings_run, words_by_mode[0], words_by_mode[1], words_by_mode[2]);
        $display("Checked %0d results; input stall held a word for %0d cycles; %0d mismatches.",
                 results_checked, stall_cycles, err_count);
        if (err_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
